FILE: design/ncc_pkg.sv
package ncc_pkg;

    // feature and accumulator widths
    localparam int FEAT_W  = 11;
    localparam int SUM_W   = 32;
    localparam int SCORE_W = 16;
    localparam int LEN_W   = $clog2(SUM_W + 1);
    localparam int STEP_W  = $clog2(SUM_W);

    // longest vector pair that still gives a score
    localparam int MAX_LEN = 512;
    localparam int CNT_W   = $clog2(MAX_LEN + 2);

    // configuration register map
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_MAX = 1'b1;

    localparam logic signed [FEAT_W-1:0] FEATURE_MIN_RST = -11'sd1023;
    localparam logic signed [FEAT_W-1:0] FEATURE_MAX_RST = 11'sd1023;

    // stream packing
    localparam int S_TDATA_W = ((2 * FEAT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = SCORE_W;
    localparam int M_TUSER_W = 2;

    // signed shift amounts of the grade computation
    typedef logic signed [7:0] shift_t;
    localparam shift_t SHIFT_NORM    = 8'sd16;
    localparam shift_t SHIFT_RESCALE = 8'sd12;
    localparam shift_t SHIFT_SPAN    = 8'sd32;
    localparam shift_t SHIFT_ZERO    = 8'sd0;

    typedef struct packed {
        logic signed [FEAT_W-1:0] probe_value;
        logic signed [FEAT_W-1:0] gallery_value;
        logic                     last_element;
        logic                     fault;
    } item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               out_of_range;
        logic               too_long;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/integer_ncc_vector_score_top.sv
// Integer normalized cross-correlation score of two feature vectors. Each input
// transaction carries one element pair (probe and gallery feature, 11-bit signed)
// and tlast on the final pair of the vectors. The block sums the dot product and
// both squared norms; on the last pair it emits one output transaction with a
// 16-bit unsigned score (4096 for equal vectors, 0 for negative correlation) and two
// flags: out_of_range when any feature fell outside feature_min..feature_max, and
// too_long when more than 512 pairs arrived, which forces the score to 0. Each
// element pair occupies the block while a single multiplier forms the three
// products one after another; the last pair then also holds the block for two
// runs of the one-bit-per-cycle divider and a 5-step bit length search. s_tready
// is low while a pair is being worked on. The finished result sits in an output
// register, so the next pair is taken while that result waits for m_tready.
// Configuration writes are taken at any time and should only be issued while the
// block is idle.
module integer_ncc_vector_score_top
    import ncc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    // element pair stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,   // probe_value, gallery_value
    input  logic                          s_tlast,   // last_element

    // score stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,   // score
    output logic [M_TUSER_W-1:0]          m_tuser,   // out_of_range, too_long

    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic signed [FEAT_W-1:0]      cfg_data
);

    logic signed [FEAT_W-1:0] feature_min_reg;
    logic signed [FEAT_W-1:0] feature_max_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    item_t                    item;
    logic                     core_ready;
    logic                     res_valid;
    logic                     res_take;
    result_t                  res;

    // configuration port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_min_reg <= FEATURE_MIN_RST;
            feature_max_reg <= FEATURE_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FEATURE_MIN: feature_min_reg <= cfg_data;
                REG_FEATURE_MAX: feature_max_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // unpack the element pair and check both features against the window
    always_comb
    begin
        item.probe_value   = s_tdata[FEAT_W-1:0];
        item.gallery_value = s_tdata[2*FEAT_W-1:FEAT_W];
        item.last_element  = s_tlast;
        item.fault         = (item.probe_value < feature_min_reg)
                          || (item.probe_value > feature_max_reg)
                          || (item.gallery_value < feature_min_reg)
                          || (item.gallery_value > feature_max_reg);
    end

    ncc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (core_ready),
        .item      (item),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign s_tready = core_ready;

    // output register: a result moves in when the slot is empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.score;
    assign m_tuser  = {out_reg.too_long, out_reg.out_of_range};

endmodule

FILE: design/ncc_div.sv
// restoring divider, one quotient bit per cycle
module ncc_div
    import ncc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  dvs_reg;

    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[SUM_W] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ~diff[SUM_W]};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: design/ncc_core.sv
// accumulation and grade sequencer around one shared multiplier and the divider
module ncc_core
    import ncc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_take,
    output result_t res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MPG,
        S_MPP,
        S_MGG,
        S_AGG,
        S_LOAD,
        S_NORM,
        S_SHIFT,
        S_DIV1S,
        S_DIV1,
        S_DIV2,
        S_MULQ,
        S_FINAL,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_LEN);
    localparam logic [2:0]       NORM_LAST = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(SUM_W);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic               range_fault_reg;
    logic [SUM_W-1:0]   corr_sum_reg;
    logic [SUM_W-1:0]   probe_norm_sum_reg;
    logic [SUM_W-1:0]   gallery_norm_sum_reg;
    logic [2:0]         step_reg;

    logic signed [FEAT_W-1:0] probe_reg;
    logic signed [FEAT_W-1:0] gallery_reg;
    logic               last_reg;
    logic [SUM_W-1:0]   prod_reg;
    logic [SUM_W-1:0]   ucorr_reg;
    logic [SUM_W-1:0]   n1_reg;
    logic [SUM_W-1:0]   n2_reg;
    logic [SUM_W-1:0]   lane_reg [3];
    logic [LEN_W-1:0]   len_reg  [3];
    shift_t             s1_reg;
    shift_t             s2_reg;
    logic [SUM_W-1:0]   q1_reg;
    logic [SCORE_W-1:0] score_reg;

    logic [SUM_W-1:0]   mul_a;
    logic [SUM_W-1:0]   mul_b;
    logic [2*SUM_W-1:0] mul_full;
    logic               accept;
    logic               div_start;
    logic [SUM_W-1:0]   div_dvd;
    logic [SUM_W-1:0]   div_dvs;
    logic [SUM_W-1:0]   div_quo;
    div_stat_t          div_stat;
    shift_t             s_sel;
    shift_t             s_neg;
    logic [STEP_W-1:0]  norm_k;
    logic [SUM_W-1:0]   top_mask;
    shift_t             cm;
    shift_t             m1;
    shift_t             m2;
    shift_t             lim;
    shift_t             d1;
    shift_t             d2;
    shift_t             t1;
    shift_t             t2;
    shift_t             back;
    shift_t             back_neg;
    logic [SUM_W-1:0]   grade;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = {{(SUM_W-FEAT_W){probe_reg[FEAT_W-1]}}, probe_reg};
        mul_b = {{(SUM_W-FEAT_W){gallery_reg[FEAT_W-1]}}, gallery_reg};
        case (state_reg)
            S_MPP:
            begin
                mul_b = {{(SUM_W-FEAT_W){probe_reg[FEAT_W-1]}}, probe_reg};
            end
            S_MGG:
            begin
                mul_a = {{(SUM_W-FEAT_W){gallery_reg[FEAT_W-1]}}, gallery_reg};
            end
            S_MULQ:
            begin
                mul_a = q1_reg;
                mul_b = div_quo;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // pre-division shift of the clamped correlation
    assign s_sel   = (state_reg == S_DIV1S) ? s1_reg : s2_reg;
    assign s_neg   = -s_sel;
    assign div_dvd = s_sel[7] ? (ucorr_reg >> s_neg[STEP_W-1:0])
                              : (ucorr_reg << s_sel[STEP_W-1:0]);
    assign div_dvs = (state_reg == S_DIV1S) ? n1_reg : n2_reg;
    assign div_start = (state_reg == S_DIV1S) || (state_reg == S_DIV1 && div_stat.done);

    ncc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // halving search step for the bit length lanes
    always_comb
    begin
        case (step_reg)
            3'd0:    norm_k = STEP_W'(16);
            3'd1:    norm_k = STEP_W'(8);
            3'd2:    norm_k = STEP_W'(4);
            3'd3:    norm_k = STEP_W'(2);
            default: norm_k = STEP_W'(1);
        endcase
        top_mask = ~({SUM_W{1'b1}} >> norm_k);
    end

    // shift amounts from the three bit lengths
    assign cm  = $signed({2'b00, len_reg[0]});
    assign m1  = $signed({2'b00, len_reg[1]});
    assign m2  = $signed({2'b00, len_reg[2]});
    assign lim = SHIFT_SPAN - cm;
    assign d1  = cm - m1;
    assign d2  = cm - m2;
    assign t1  = SHIFT_NORM - (d1[7] ? SHIFT_ZERO : d1);
    assign t2  = SHIFT_NORM - (d2[7] ? SHIFT_ZERO : d2);

    // final rescale of the quotient product
    assign back     = s1_reg + s2_reg - SHIFT_RESCALE;
    assign back_neg = -back;
    always_comb
    begin
        if (back_neg >= SHIFT_SPAN)
            grade = '0;
        else if (!back_neg[7])
            grade = prod_reg << back_neg[STEP_W-1:0];
        else
            grade = prod_reg >> back[STEP_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_MPG;
            S_MPG:   state_next = S_MPP;
            S_MPP:   state_next = S_MGG;
            S_MGG:   state_next = S_AGG;
            S_AGG:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (count_reg > CNT_MAX)
                    state_next = S_DONE;
                else
                    state_next = S_LOAD;
            end
            S_LOAD:  state_next = S_NORM;
            S_NORM:  if (step_reg == NORM_LAST) state_next = S_SHIFT;
            S_SHIFT: state_next = S_DIV1S;
            S_DIV1S: state_next = S_DIV1;
            S_DIV1:  if (div_stat.done) state_next = S_DIV2;
            S_DIV2:  if (div_stat.done) state_next = S_MULQ;
            S_MULQ:  state_next = S_FINAL;
            S_FINAL: state_next = S_DONE;
            S_DONE:  if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            count_reg            <= '0;
            range_fault_reg      <= 1'b0;
            corr_sum_reg         <= '0;
            probe_norm_sum_reg   <= '0;
            gallery_norm_sum_reg <= '0;
            step_reg             <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        range_fault_reg <= range_fault_reg | item.fault;
                        if (count_reg <= CNT_MAX)
                            count_reg <= count_reg + 1'b1;
                    end
                end
                S_MPP:   corr_sum_reg         <= corr_sum_reg + prod_reg;
                S_MGG:   probe_norm_sum_reg   <= probe_norm_sum_reg + prod_reg;
                S_AGG:   gallery_norm_sum_reg <= gallery_norm_sum_reg + prod_reg;
                S_LOAD:  step_reg <= '0;
                S_NORM:  step_reg <= step_reg + 1'b1;
                S_DONE:
                begin
                    if (res_take)
                    begin
                        count_reg            <= '0;
                        range_fault_reg      <= 1'b0;
                        corr_sum_reg         <= '0;
                        probe_norm_sum_reg   <= '0;
                        gallery_norm_sum_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[SUM_W-1:0];
        if (accept)
        begin
            probe_reg   <= item.probe_value;
            gallery_reg <= item.gallery_value;
            last_reg    <= item.last_element;
        end
        if (state_reg == S_AGG)
            score_reg <= '0;
        if (state_reg == S_LOAD)
        begin
            ucorr_reg   <= corr_sum_reg[SUM_W-1] ? '0 : corr_sum_reg;
            n1_reg      <= (probe_norm_sum_reg == '0) ? SUM_W'(1) : probe_norm_sum_reg;
            n2_reg      <= (gallery_norm_sum_reg == '0) ? SUM_W'(1) : gallery_norm_sum_reg;
            lane_reg[0] <= corr_sum_reg[SUM_W-1] ? '0 : corr_sum_reg;
            lane_reg[1] <= (probe_norm_sum_reg == '0) ? SUM_W'(1) : probe_norm_sum_reg;
            lane_reg[2] <= (gallery_norm_sum_reg == '0) ? SUM_W'(1) : gallery_norm_sum_reg;
            len_reg[0]  <= (corr_sum_reg[SUM_W-1] || corr_sum_reg == '0) ? '0 : LEN_FULL;
            len_reg[1]  <= LEN_FULL;
            len_reg[2]  <= LEN_FULL;
        end
        if (state_reg == S_NORM)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (len_reg[i] != '0 && (lane_reg[i] & top_mask) == '0)
                begin
                    lane_reg[i] <= lane_reg[i] << norm_k;
                    len_reg[i]  <= len_reg[i] - LEN_W'(norm_k);
                end
            end
        end
        if (state_reg == S_SHIFT)
        begin
            s1_reg <= (t1 < lim) ? t1 : lim;
            s2_reg <= (t2 < lim) ? t2 : lim;
        end
        if (state_reg == S_DIV1 && div_stat.done)
            q1_reg <= div_quo;
        if (state_reg == S_FINAL)
            score_reg <= grade[SCORE_W-1:0];
    end

    assign res_valid        = (state_reg == S_DONE);
    assign res.score        = score_reg;
    assign res.out_of_range = range_fault_reg;
    assign res.too_long     = (count_reg > CNT_MAX);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX + 1'b1)
        else $error("element count beyond saturation");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (count_reg == '0 && corr_sum_reg == '0 && !range_fault_reg))
        else $error("accumulators not cleared after result");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> count_reg != '0)
        else $error("accepted element not counted");

    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.too_long) |-> res.score == '0)
        else $error("too long vector with nonzero score");

endmodule
